// ----- src/cd_pkg.sv -----
// cd_pkg: opcodes, status codes and the command classification type
// shared by the circular deque front end, back end and top level.
// No dependencies.
`timescale 1ns / 1ps

package cd_pkg;

    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DEL_FRONT = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_DEL_BACK  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic insert;    // 1: insert, 0: delete
        logic at_front;  // 1: front end, 0: back end
    } cmd_kind_t;

endpackage

// ----- src/circular_deque.sv -----
// circular_deque: top level of the double-ended queue; wires the front end
// (accept, classify, command queue) to the back end (execute, memory, result).
// Depends on cd_pkg, cd_front, cd_back.
//
//  channel   dir  handshake                    tdata (low bit up)               tuser
//  s_axis    in   s_axis_tvalid/s_axis_tready  value                            opcode
//  m_axis    out  m_axis_tvalid/m_axis_tready  removed_value, occupancy         status
//
// One item per cycle sustained while m_axis is not stalled; a result item passes
// the command queue entry, the pending stage with the registered read port of
// the entry memory, and the result register before it is presented on m_axis.
// Reset clears indices and fill count at once; entries keep whatever they hold.
// Either side may stall freely: the two-entry command queue and the result
// register let input and output stall independently.
`timescale 1ns / 1ps

module circular_deque #(
    parameter int DEPTH      = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [DATA_WIDTH-1:0] value, rest zero
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // [1:0] opcode
    input  logic [cd_pkg::OPCODE_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [DATA_WIDTH-1:0] removed_value, then occupancy, rest zero
    output logic [((DATA_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
    // [1:0] status
    output logic [cd_pkg::STATUS_W-1:0]        m_axis_tuser
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W = ((DATA_WIDTH + CNT_W + 7) / 8) * 8;

    logic                           c_valid, c_ready;
    cd_pkg::cmd_kind_t              c_kind;
    logic signed [DATA_WIDTH-1:0]   c_value;
    logic signed [DATA_WIDTH-1:0]   in_value;
    logic signed [DATA_WIDTH-1:0]   res_removed;
    logic [CNT_W-1:0]               res_occupancy;

    assign in_value = s_axis_tdata[DATA_WIDTH-1:0];

    cd_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (s_axis_tuser),
        .in_value  (in_value),
        .c_valid   (c_valid),
        .c_ready   (c_ready),
        .c_kind    (c_kind),
        .c_value   (c_value)
    );

    cd_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .c_valid       (c_valid),
        .c_ready       (c_ready),
        .c_kind        (c_kind),
        .c_value       (c_value),
        .res_valid     (m_axis_tvalid),
        .res_ready     (m_axis_tready),
        .res_removed   (res_removed),
        .res_status    (m_axis_tuser),
        .res_occupancy (res_occupancy)
    );

    // pack removed value low, occupancy above, zero fill to whole bytes
    assign m_axis_tdata = OUT_W'({res_occupancy, res_removed});

endmodule

// ----- src/cd_front.sv -----
// cd_front: accepts request items, classifies the opcode and holds them in
// a two-entry command queue toward the back end.
// Depends on cd_pkg.
`timescale 1ns / 1ps

module cd_front #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cd_pkg::OPCODE_W-1:0]    in_opcode,
    input  logic signed [DATA_WIDTH-1:0]   in_value,
    output logic                           c_valid,
    input  logic                           c_ready,
    output cd_pkg::cmd_kind_t              c_kind,
    output logic signed [DATA_WIDTH-1:0]   c_value
);

    localparam int QDEPTH = 2;
    localparam int QCNT_W = 2;

    cd_pkg::cmd_kind_t          q_kind_reg [QDEPTH];
    logic [DATA_WIDTH-1:0]      q_val_reg  [QDEPTH];
    logic                       wr_ptr_reg, wr_ptr_next;
    logic                       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]          cnt_reg, cnt_next;
    cd_pkg::cmd_kind_t          kind_dec;
    logic                       push, pop;

    always_comb
    begin
        kind_dec = '0;
        case (in_opcode)
            cd_pkg::OP_INS_FRONT:
            begin
                kind_dec.insert   = 1'b1;
                kind_dec.at_front = 1'b1;
            end
            cd_pkg::OP_INS_BACK:
            begin
                kind_dec.insert   = 1'b1;
                kind_dec.at_front = 1'b0;
            end
            cd_pkg::OP_DEL_FRONT:
            begin
                kind_dec.insert   = 1'b0;
                kind_dec.at_front = 1'b1;
            end
            cd_pkg::OP_DEL_BACK:
            begin
                kind_dec.insert   = 1'b0;
                kind_dec.at_front = 1'b0;
            end
            default:
            begin
                kind_dec = '0;
            end
        endcase
    end

    assign in_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign c_valid  = (cnt_reg != '0);
    assign pop      = c_valid && c_ready;
    assign c_kind   = q_kind_reg[rd_ptr_reg];
    assign c_value  = q_val_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_kind_reg[wr_ptr_reg] <= kind_dec;
            q_val_reg[wr_ptr_reg]  <= in_value;
        end
    end

endmodule

// ----- src/cd_back.sv -----
// cd_back: executes deque commands against the circular entry memory,
// tracks head, tail and fill count, and registers each result item.
// Depends on cd_pkg.
`timescale 1ns / 1ps

module cd_back #(
    parameter int DEPTH      = 4,
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 2,
    parameter int CNT_W      = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           c_valid,
    output logic                           c_ready,
    input  cd_pkg::cmd_kind_t              c_kind,
    input  logic signed [DATA_WIDTH-1:0]   c_value,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic signed [DATA_WIDTH-1:0]   res_removed,
    output logic [cd_pkg::STATUS_W-1:0]    res_status,
    output logic [CNT_W-1:0]               res_occupancy
);

    logic [DATA_WIDTH-1:0]          mem [DEPTH];
    logic [DATA_WIDTH-1:0]          rd_data_reg;

    logic [IDX_W-1:0]               head_reg, head_next;
    logic [IDX_W-1:0]               tail_reg, tail_next;
    logic [CNT_W-1:0]               count_reg, count_next;

    logic                           pend_vld_reg, pend_vld_next;
    logic                           pend_rd_reg;
    logic [cd_pkg::STATUS_W-1:0]    pend_status_reg;
    logic [CNT_W-1:0]               pend_occ_reg;

    logic                           out_vld_reg, out_vld_next;
    logic signed [DATA_WIDTH-1:0]   out_removed_reg;
    logic [cd_pkg::STATUS_W-1:0]    out_status_reg;
    logic [CNT_W-1:0]               out_occ_reg;

    logic                           fire, pend_move;
    logic                           mem_we, mem_re;
    logic [IDX_W-1:0]               wr_addr, rd_addr;
    logic [cd_pkg::STATUS_W-1:0]    status_c;
    logic                           full, empty;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    assign pend_move = pend_vld_reg && (!out_vld_reg || res_ready);
    assign c_ready   = !pend_vld_reg || pend_move;
    assign fire      = c_valid && c_ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        wr_addr    = '0;
        rd_addr    = c_kind.at_front ? head_reg : tail_reg;
        status_c   = cd_pkg::ST_DONE;
        if (fire)
        begin
            if (c_kind.insert)
            begin
                if (full)
                begin
                    status_c = cd_pkg::ST_OVERFLOW;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (empty)
                    begin
                        // restart both ends at slot zero
                        head_next = '0;
                        tail_next = '0;
                        wr_addr   = '0;
                    end
                    else if (c_kind.at_front)
                    begin
                        head_next = idx_prev(head_reg);
                        wr_addr   = head_next;
                    end
                    else
                    begin
                        tail_next = idx_next(tail_reg);
                        wr_addr   = tail_next;
                    end
                end
            end
            else
            begin
                if (empty)
                begin
                    status_c = cd_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    mem_re     = 1'b1;
                    count_next = count_reg - 1'b1;
                    // the last element leaves the indices where they are
                    if (count_reg != CNT_W'(1))
                    begin
                        if (c_kind.at_front)
                        begin
                            head_next = idx_next(head_reg);
                        end
                        else
                        begin
                            tail_next = idx_prev(tail_reg);
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        if (fire)
        begin
            pend_vld_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (pend_move)
        begin
            out_vld_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= c_value;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pend_rd_reg     <= mem_re;
            pend_status_reg <= status_c;
            pend_occ_reg    <= count_next;
        end
        // rd_data_reg still holds the pending item's read data this cycle
        if (pend_move)
        begin
            out_removed_reg <= pend_rd_reg ? rd_data_reg : '0;
            out_status_reg  <= pend_status_reg;
            out_occ_reg     <= pend_occ_reg;
        end
    end

    assign res_valid     = out_vld_reg;
    assign res_removed   = out_removed_reg;
    assign res_status    = out_status_reg;
    assign res_occupancy = out_occ_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count exceeds depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && c_kind.insert && !full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not grow the queue");

    a_delete_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !c_kind.insert && empty |=> pend_status_reg == cd_pkg::ST_UNDERFLOW
            && !pend_rd_reg && count_reg == '0)
        else $error("delete from empty queue not flagged as underflow");

    a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_status_reg != cd_pkg::ST_DONE |-> out_removed_reg == '0)
        else $error("failed operation returned nonzero data");

    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg && !pend_move |=> pend_vld_reg && $stable(pend_status_reg)
            && $stable(pend_occ_reg))
        else $error("pending result lost while output stalled");
`endif

endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for circular_deque; a directed table, then
// random traffic with bursty input, stalling output and a forced fill-up.
// Depends on cd_pkg and circular_deque from src.
`timescale 1ns / 1ps

module tb_top;

    localparam int DQ_DEPTH    = 4;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [31:0] removed;
        logic [1:0]  status;
        logic [2:0]  occ;
    } dq_result_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
        logic        fixed;   // want holds a typed-in result
        dq_result_t  want;
    } dq_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // shadow deque
    logic [31:0] dq_mem [DQ_DEPTH];
    logic [1:0]  dq_front = '0;
    logic [1:0]  dq_back = '0;
    logic [2:0]  dq_fill = '0;

    dq_req_t     table_q[$];
    dq_req_t     sent_q[$];
    dq_result_t  result_q[$];
    int          err_cnt = 0;
    int          cycle_cnt = 0;
    int          tx_burst = 0;
    bit          tx_nogap = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          rx_mode = 0;
    int          rx_left = 0;

    circular_deque u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic dq_result_t deque_apply(input logic [1:0] op, input logic [31:0] val);
        dq_result_t r;
        r.removed = '0;
        r.status  = cd_pkg::ST_DONE;
        if (op == cd_pkg::OP_INS_FRONT || op == cd_pkg::OP_INS_BACK)
        begin
            if (dq_fill == DQ_DEPTH)
                r.status = cd_pkg::ST_OVERFLOW;
            else
            begin
                if (dq_fill == 3'd0)
                begin
                    dq_front  = '0;
                    dq_back   = '0;
                    dq_mem[0] = val;
                end
                else if (op == cd_pkg::OP_INS_FRONT)
                begin
                    dq_front = dq_front - 2'd1;
                    dq_mem[dq_front] = val;
                end
                else
                begin
                    dq_back = dq_back + 2'd1;
                    dq_mem[dq_back] = val;
                end
                dq_fill = dq_fill + 3'd1;
            end
        end
        else
        begin
            if (dq_fill == 3'd0)
                r.status = cd_pkg::ST_UNDERFLOW;
            else
            begin
                if (op == cd_pkg::OP_DEL_FRONT)
                begin
                    r.removed = dq_mem[dq_front];
                    if (dq_fill > 3'd1)
                        dq_front = dq_front + 2'd1;
                end
                else
                begin
                    r.removed = dq_mem[dq_back];
                    if (dq_fill > 3'd1)
                        dq_back = dq_back - 2'd1;
                end
                dq_fill = dq_fill - 3'd1;
            end
        end
        r.occ = dq_fill;
        return r;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [31:0] val, input logic fixed,
                           input logic [31:0] rem, input logic [1:0] st, input logic [2:0] occ);
        dq_req_t r;
        r.op           = op;
        r.value        = val;
        r.fixed        = fixed;
        r.want.removed = rem;
        r.want.status  = st;
        r.want.occ     = occ;
        table_q.push_back(r);
    endtask

    // Call at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_req(input dq_req_t r);
        int gap;
        if (!tx_nogap && tx_burst == 0)
        begin
            tx_burst = $urandom_range(1, 32);
            gap = $urandom_range(0, 8);
            repeat (gap)
            begin
                s_valid <= 1'b0;
                s_data  <= $urandom;
                s_user  <= $urandom_range(0, 3);
                @(negedge clk);
            end
        end
        if (tx_burst > 0)
            tx_burst--;
        s_valid <= 1'b1;
        s_data  <= r.value;
        s_user  <= r.op;
        sent_q.push_back(r);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        dq_req_t r;
        int bias;
        bias = 50;
        for (int i = 0; i < count; i++)
        begin
            // swing between filling and emptying so both ends get hit often
            if (i % 20 == 0)
                case ($urandom_range(0, 2))
                    0: bias = 15;
                    1: bias = 50;
                    default: bias = 85;
                endcase
            if ($urandom_range(0, 99) < bias)
                r.op = $urandom_range(0, 1) ? cd_pkg::OP_INS_FRONT : cd_pkg::OP_INS_BACK;
            else
                r.op = $urandom_range(0, 1) ? cd_pkg::OP_DEL_FRONT : cd_pkg::OP_DEL_BACK;
            case ($urandom_range(0, 7))
                0: r.value = 32'h8000_0000;
                1: r.value = 32'h7fff_ffff;
                2: r.value = 32'h0000_0000;
                3: r.value = 32'hffff_ffff;
                default: r.value = $urandom;
            endcase
            r.fixed = 1'b0;
            r.want  = '0;
            send_req(r);
        end
    endtask

    // Drop valid and wait until every result is back.
    task automatic drain();
        s_valid <= 1'b0;
        wait (result_q.size() == 0);
        @(negedge clk);
    endtask

    // Receiver: a hold-off on request, otherwise stall patterns of varying density.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(4, 40);
            end
            rx_left--;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= ($urandom_range(0, 7) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Predict on each accepted item, check each accepted result.
    always @(posedge clk)
    begin : scoreboard
        dq_req_t    req;
        dq_result_t want;
        dq_result_t got;
        if (rst_n)
        begin
            if (s_valid && s_axis_tready)
            begin
                req  = sent_q.pop_front();
                want = deque_apply(req.op, req.value);
                if (req.fixed)
                    want = req.want;
                result_q.push_back(want);
            end
            if (m_axis_tvalid && m_ready)
            begin
                got.removed = m_axis_tdata[31:0];
                got.occ     = m_axis_tdata[34:32];
                got.status  = m_axis_tuser;
                if (result_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result removed=%h status=%0d occ=%0d",
                             $time, got.removed, got.status, got.occ);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.removed !== want.removed || got.status !== want.status ||
                        got.occ !== want.occ)
                    begin
                        err_cnt++;
                        $display({"%0t: expected removed=%h status=%0d occ=%0d,",
                                  " got removed=%h status=%0d occ=%0d"},
                                 $time, want.removed, want.status, want.occ,
                                 got.removed, got.status, got.occ);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < DQ_DEPTH; i++)
            dq_mem[i] = '0;

        // empty, extremes, single element, both wraps, full, refill after empty
        add_row(cd_pkg::OP_DEL_FRONT, 32'h1234_5678, 1'b1, 32'h0, cd_pkg::ST_UNDERFLOW, 3'd0);
        add_row(cd_pkg::OP_DEL_BACK,  32'hffff_ffff, 1'b1, 32'h0, cd_pkg::ST_UNDERFLOW, 3'd0);
        add_row(cd_pkg::OP_INS_BACK,  32'h7fff_ffff, 1'b1, 32'h0, cd_pkg::ST_DONE, 3'd1);
        add_row(cd_pkg::OP_DEL_BACK,  32'h0000_0000, 1'b1, 32'h7fff_ffff, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_INS_FRONT, 32'h8000_0000, 1'b1, 32'h0, cd_pkg::ST_DONE, 3'd1);
        add_row(cd_pkg::OP_DEL_FRONT, 32'h0000_0000, 1'b1, 32'h8000_0000, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_INS_FRONT, 32'hffff_ffff, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_INS_FRONT, 32'h0000_0000, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_INS_BACK,  32'h0000_0001, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_INS_BACK,  32'h5555_5555, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_INS_FRONT, 32'h0000_0005, 1'b1, 32'h0, cd_pkg::ST_OVERFLOW, 3'd4);
        add_row(cd_pkg::OP_INS_BACK,  32'h0000_0006, 1'b1, 32'h0, cd_pkg::ST_OVERFLOW, 3'd4);
        add_row(cd_pkg::OP_DEL_BACK,  32'hffff_ffff, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_DEL_FRONT, 32'h0000_0000, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_DEL_BACK,  32'h0000_0000, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_DEL_FRONT, 32'h0000_0000, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_DEL_BACK,  32'h0000_0000, 1'b1, 32'h0, cd_pkg::ST_UNDERFLOW, 3'd0);
        add_row(cd_pkg::OP_INS_BACK,  32'haaaa_aaaa, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_INS_BACK,  32'h0000_0002, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_DEL_FRONT, 32'h0000_0000, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_INS_BACK,  32'h0000_0003, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_INS_BACK,  32'h0000_0004, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_DEL_BACK,  32'h0000_0000, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);
        add_row(cd_pkg::OP_DEL_FRONT, 32'h0000_0000, 1'b0, 32'h0, cd_pkg::ST_DONE, 3'd0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (table_q[i])
            send_req(table_q[i]);
        drain();

        send_random(700);

        // hold the output off while the input keeps offering, so the block fills
        tx_nogap = 1'b1;
        hold_req = 1'b1;
        send_random(40);
        tx_nogap = 1'b0;
        drain();

        send_random(860);
        drain();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
src/cd_pkg.sv
src/cd_front.sv
src/cd_back.sv
src/circular_deque.sv
bench/tb_top.sv
